FILE: hdl/fdrv_pkg.sv
`timescale 1ns / 1ps
package fdrv_pkg;

  localparam int NUM_W  = 32;
  localparam int SIZE_W = 24;
  localparam int DESC_W = NUM_W + SIZE_W;
  localparam int MARK_W = 16;
  localparam int LVL_W  = 5;
  localparam int CFG_W  = 5;

  localparam logic [MARK_W-1:0] SOI_MARK       = 16'hFFD8;
  localparam logic [MARK_W-1:0] EOI_MARK       = 16'hFFD9;
  localparam logic [SIZE_W-1:0] MIN_FRAME_SIZE = 24'd4;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic REG_DEPTH  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic [1:0]       status;
    logic             dropped;
    logic [LVL_W-1:0] fill;
    logic             above;
  } res_t;

endpackage

FILE: hdl/fdrv_ram.sv
`timescale 1ns / 1ps
module fdrv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/fdrv_ctrl.sv
`timescale 1ns / 1ps
module fdrv_ctrl #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fdrv_pkg::CFG_W-1:0]   depth_i,
  input  logic [fdrv_pkg::CFG_W-1:0]   thresh_i,
  input  logic                         clear_i,
  input  logic                         go_i,
  input  logic                         mode_i,
  input  logic                         frame_ok_i,
  output fdrv_pkg::res_t               res_o,
  output logic                         ram_we_o,
  output logic                         ram_re_o,
  output logic [$clog2(MAX_DEPTH)-1:0] ram_addr_o
);

  import fdrv_pkg::*;

  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int DCAP  = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
  localparam int NW    = ((IDX_W > LVL_W) ? IDX_W : LVL_W) + 1;
  localparam logic [LVL_W-1:0] DCAP_L = LVL_W'(DCAP);

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [LVL_W-1:0] cnt_q, cnt_d;
  logic [LVL_W-1:0] depth;
  logic [IDX_W-1:0] wr_next, rd_next;
  logic [NW-1:0]    wr_inc, rd_inc;
  logic             full;

  // zero runs as depth one, anything above the ring size saturates
  always_comb begin
    depth = depth_i;
    if (depth_i == '0) begin
      depth = LVL_W'(1);
    end else if (depth_i > DCAP_L) begin
      depth = DCAP_L;
    end
  end

  assign wr_inc  = NW'(wr_idx_q) + NW'(1);
  assign rd_inc  = NW'(rd_idx_q) + NW'(1);
  assign wr_next = (wr_inc >= NW'(depth)) ? '0 : wr_inc[IDX_W-1:0];
  assign rd_next = (rd_inc >= NW'(depth)) ? '0 : rd_inc[IDX_W-1:0];
  assign full    = (cnt_q >= depth);

  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    cnt_d      = cnt_q;
    res_o      = '0;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    ram_addr_o = wr_idx_q;
    if (mode_i == MODE_ENQ) begin
      if (!frame_ok_i) begin
        res_o.status = ST_INVALID;
      end else begin
        ram_we_o = go_i;
        wr_idx_d = wr_next;
        if (full) begin
          // overwrite the oldest slot
          rd_idx_d      = rd_next;
          res_o.dropped = 1'b1;
        end else begin
          cnt_d = cnt_q + LVL_W'(1);
        end
      end
    end else begin
      ram_addr_o = rd_idx_q;
      if (cnt_q == '0) begin
        res_o.status = ST_EMPTY;
      end else begin
        ram_re_o = go_i;
        rd_idx_d = rd_next;
        cnt_d    = cnt_q - LVL_W'(1);
      end
    end
    res_o.fill  = cnt_d;
    res_o.above = (cnt_d >= thresh_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else if (clear_i) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else if (go_i) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hdl/frame_descriptor_ring_validated.sv
`timescale 1ns / 1ps
// Ring of frame descriptors (frame number, byte size) held in one descriptor
// RAM of MAX_DEPTH entries, of which queue_depth are in use. An enqueue is
// checked for a JPEG frame (size at least 4, markers FFD8 and FFD9); a valid
// one is written into the RAM in its transfer cycle and a full ring loses its
// oldest entry. A dequeue reads the oldest slot. The result of an enqueue, a
// rejected frame or a dequeue of an empty ring appears in the output register
// in the cycle after the input transfer; a new item can be taken in the cycle
// the output is accepted. A dequeue that returns an entry passes the RAM's
// registered read, then the output register, and takes no input meanwhile.
// Writing queue_depth empties the ring; no clearing pass follows reset.
module frame_descriptor_ring_validated #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [fdrv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [fdrv_pkg::NUM_W-1:0]     frame_number_i,
  input  logic [fdrv_pkg::SIZE_W-1:0]    frame_size_i,
  input  logic [fdrv_pkg::MARK_W-1:0]    start_marker_i,
  input  logic [fdrv_pkg::MARK_W-1:0]    end_marker_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic                           dropped_oldest_o,
  output logic [fdrv_pkg::NUM_W-1:0]     out_frame_number_o,
  output logic [fdrv_pkg::SIZE_W-1:0]    out_frame_size_o,
  output logic [fdrv_pkg::LVL_W-1:0]     fill_level_o,
  output logic                           above_threshold_o
);

  import fdrv_pkg::*;

  localparam int IDX_W = $clog2(MAX_DEPTH);

  logic [CFG_W-1:0]  depth_q, thresh_q;
  logic              clear;
  logic              acc, frame_ok;
  res_t              res;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_addr;
  logic [DESC_W-1:0] ram_rdata;
  logic              pend_q;
  logic              out_valid_q;
  res_t              res_q;
  logic [NUM_W-1:0]  onum_q;
  logic [SIZE_W-1:0] osize_q;

  assign clear = cfg_we_i && (cfg_index_i == REG_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= CFG_W'(16);
      thresh_q <= CFG_W'(5);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_DEPTH) begin
        depth_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_THRESH) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign frame_ok   = (frame_size_i >= MIN_FRAME_SIZE) && (start_marker_i == SOI_MARK) &&
                      (end_marker_i == EOI_MARK);

  fdrv_ctrl #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .depth_i    (depth_q),
    .thresh_i   (thresh_q),
    .clear_i    (clear),
    .go_i       (acc),
    .mode_i     (mode_i),
    .frame_ok_i (frame_ok),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr)
  );

  fdrv_ram #(
    .WIDTH(DESC_W),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i ({frame_number_i, frame_size_i}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= acc && ram_re;
      if (pend_q || (acc && !ram_re)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the status fields while the descriptor read completes
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q   <= res;
      onum_q  <= '0;
      osize_q <= '0;
    end else if (pend_q) begin
      onum_q  <= ram_rdata[DESC_W-1:SIZE_W];
      osize_q <= ram_rdata[SIZE_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = res_q.status;
  assign dropped_oldest_o   = res_q.dropped;
  assign fill_level_o       = res_q.fill;
  assign above_threshold_o  = res_q.above;
  assign out_frame_number_o = onum_q;
  assign out_frame_size_o   = osize_q;

  a_pend_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o && !out_valid_q)
    else $error("input taken while a descriptor read is outstanding");

  a_read_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && ram_re |=> pend_q ##1 out_valid_q)
    else $error("dequeue read did not reach the output register");

  a_empty_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status != ST_OK) |-> (onum_q == '0) && (osize_q == '0) &&
    !res_q.dropped)
    else $error("data or drop flag on a failed operation");

  a_drop_at_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.dropped |-> (res_q.fill != '0) && (res_q.status == ST_OK))
    else $error("oldest entry dropped with an empty ring");

endmodule
